// ===== rtl/esm_pkg.sv =====
// esm_pkg: shared constants, types and codes of the early stopping monitor.
// Used by esm_div and early_stopping_monitor; no dependencies.
package esm_pkg;

  localparam int HISTORY_DEPTH = 16;
  localparam int LOSS_WIDTH    = 32;

  localparam int IDX_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W   = LOSS_WIDTH + CNT_W;
  localparam int DIV_W   = (SUM_W > 32) ? SUM_W : 32;
  localparam int DVS_W   = 16;
  localparam int DCNT_W  = $clog2(DIV_W + 1);
  localparam int MUL_A_W = (LOSS_WIDTH > 32) ? LOSS_WIDTH : 32;
  localparam int PROD_W  = MUL_A_W + 16;

  localparam logic [31:0] START_PATIENCE_RESET = 32'd4000;

  // configuration register indexes
  localparam logic [2:0] REG_CHECK_INTERVAL    = 3'd0;
  localparam logic [2:0] REG_IMPROVE_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_PATIENCE_GROWTH   = 3'd2;
  localparam logic [2:0] REG_BOX_SIZE          = 3'd3;
  localparam logic [2:0] REG_START_PATIENCE    = 3'd4;

  // stop codes
  localparam logic [1:0] STOP_CONTINUE = 2'd0;
  localparam logic [1:0] STOP_NO_IMPR  = 2'd1;
  localparam logic [1:0] STOP_INVALID  = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/early_stopping_monitor.sv =====
// early_stopping_monitor: early stopping with patience over a box-filtered loss.
// Depends on esm_pkg, esm_ram (loss history) and esm_div (shared divider).
//
// Usage: one epoch report word enters on in_* (valid/stall); one result word
// leaves on out_* for every report. The user writes registers on cfg_* only
// while the block is idle; the block itself does not enforce it. Writing
// start_patience also loads the running patience. An accepted word first runs
// the epoch through the serial divider to test the check interval. A skipped
// epoch or invalid loss then goes straight to the result. A checked valid
// loss is written to the history, the newest w = min(fill, box_size) entries
// are summed one per RAM read cycle, the sum goes through the same divider
// again and the shared 32x16 multiplier is used for the threshold test and
// the patience growth. in_stall is high while a word is in work; the next
// word is taken at the earliest in the cycle after the result is loaded.
// The result sits in an output register; a stalled receiver does not keep
// the next word from being accepted, only the finish of that word waits.
// After reset the history is empty, no best mean is known and patience holds
// 4000; no clearing pass is needed.
module early_stopping_monitor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [31:0]                     in_epoch,
  input  logic [31:0]                     in_updates,
  input  logic [esm_pkg::LOSS_WIDTH-1:0]  in_loss,
  input  logic                            in_loss_invalid,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_checked,
  output logic                            out_save_params,
  output logic [1:0]                      out_stop_code,
  output logic [esm_pkg::LOSS_WIDTH-1:0]  out_mean_loss,
  output logic [31:0]                     out_patience_now,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [31:0]                     cfg_data
);
  localparam int LW = esm_pkg::LOSS_WIDTH;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MOD   = 9'b000000010,
    S_WRITE = 9'b000000100,
    S_READ  = 9'b000001000,
    S_DIV   = 9'b000010000,
    S_BEST  = 9'b000100000,
    S_SIG   = 9'b001000000,
    S_GROW  = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [15:0] interval_r, thr_r, growth_r;
  logic [4:0]  box_r;

  // word in work
  logic [31:0] epoch_r, upd_r;
  logic [LW-1:0] loss_r, mean_r;
  logic inv_r, chk_r, save_r;

  // history bookkeeping
  logic [esm_pkg::IDX_W-1:0] slot_r, rd_addr_r;
  logic [esm_pkg::CNT_W-1:0] fill_r, window_r, issued_r;
  logic                      pend_r;
  logic [esm_pkg::SUM_W-1:0] sum_r;

  logic [LW-1:0] best_r;
  logic          best_known_r;
  logic [31:0]   patience_r;
  logic [esm_pkg::PROD_W-1:0] prod_r;

  logic out_valid_r, out_checked_r, out_save_r;
  logic [1:0] out_stop_r;
  logic [LW-1:0] out_mean_r;
  logic [31:0] out_pat_r;

  logic in_acc, read_done, out_free, sig;
  logic [esm_pkg::CNT_W-1:0] fill_inc, box_eff;
  logic [15:0] interval_eff;
  logic [esm_pkg::IDX_W-1:0] slot_inc, rd_dec;
  logic [LW-1:0] rdata;
  logic [esm_pkg::MUL_A_W-1:0] mul_a;
  logic [15:0] mul_b;
  logic [esm_pkg::PROD_W-1:0] mul_p;
  logic [esm_pkg::PROD_W-13:0] grown;
  logic [31:0] grown_sat;
  logic [1:0] stop_code;

  esm_pkg::div_stat_t div_stat;
  logic div_start;
  logic [esm_pkg::DIV_W-1:0] div_dividend, div_quo;
  logic [esm_pkg::DVS_W-1:0] div_divisor, div_rem;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && (state_r == S_IDLE);
  assign read_done = (issued_r == window_r) && !pend_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign interval_eff = (interval_r == 16'd0) ? 16'd1 : interval_r;
  assign box_eff = (box_r == 5'd0) ? esm_pkg::CNT_W'(1) :
                   (32'(box_r) > esm_pkg::HISTORY_DEPTH) ?
                   esm_pkg::CNT_W'(esm_pkg::HISTORY_DEPTH) : esm_pkg::CNT_W'(box_r);
  assign fill_inc = (32'(fill_r) < esm_pkg::HISTORY_DEPTH) ?
                    fill_r + esm_pkg::CNT_W'(1) : fill_r;
  assign slot_inc = (32'(slot_r) == esm_pkg::HISTORY_DEPTH - 1) ? '0 :
                    slot_r + esm_pkg::IDX_W'(1);
  assign rd_dec   = (rd_addr_r == '0) ? esm_pkg::IDX_W'(esm_pkg::HISTORY_DEPTH - 1) :
                    rd_addr_r - esm_pkg::IDX_W'(1);

  // shared divider: epoch % interval, then sum / window
  assign div_start    = in_acc || ((state_r == S_READ) && read_done);
  assign div_dividend = (state_r == S_IDLE) ? esm_pkg::DIV_W'(in_epoch) :
                        esm_pkg::DIV_W'(sum_r);
  assign div_divisor  = (state_r == S_IDLE) ? interval_eff : esm_pkg::DVS_W'(window_r);

  esm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  esm_ram #(.WIDTH(LW), .DEPTH(esm_pkg::HISTORY_DEPTH)) u_hist (
    .clk   (clk),
    .we    (state_r == S_WRITE),
    .waddr (slot_r),
    .wdata (loss_r),
    .re    ((state_r == S_READ) && (issued_r != window_r)),
    .raddr (rd_addr_r),
    .rdata (rdata)
  );

  // shared multiplier: best * threshold, then updates * growth
  assign mul_a = (state_r == S_BEST) ? esm_pkg::MUL_A_W'(best_r) : esm_pkg::MUL_A_W'(upd_r);
  assign mul_b = (state_r == S_BEST) ? thr_r : growth_r;
  assign mul_p = mul_a * mul_b;

  // mean * 2^16 < thr * best, exact
  assign sig = !best_known_r || ({mean_r, 16'd0} < esm_pkg::PROD_W'({prod_r}));

  assign grown     = prod_r[esm_pkg::PROD_W-1:12];
  assign grown_sat = (grown > (esm_pkg::PROD_W-12)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF :
                     grown[31:0];

  always_comb begin
    if (!chk_r) begin
      stop_code = esm_pkg::STOP_CONTINUE;
    end else if (inv_r) begin
      stop_code = esm_pkg::STOP_INVALID;
    end else if (patience_r <= epoch_r) begin
      stop_code = esm_pkg::STOP_NO_IMPR;
    end else begin
      stop_code = esm_pkg::STOP_CONTINUE;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_MOD;
      S_MOD: begin
        if (div_stat.done) begin
          state_nxt = ((div_rem != '0) || inv_r) ? S_FIN : S_WRITE;
        end
      end
      S_WRITE: state_nxt = S_READ;
      S_READ:  if (read_done) state_nxt = S_DIV;
      S_DIV:   if (div_stat.done) state_nxt = S_BEST;
      S_BEST:  state_nxt = (!best_known_r || (mean_r < best_r)) ? S_SIG : S_FIN;
      S_SIG:   state_nxt = sig ? S_GROW : S_FIN;
      S_GROW:  state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      interval_r   <= 16'd1;
      thr_r        <= 16'd65208;
      growth_r     <= 16'd8192;
      box_r        <= 5'd1;
      patience_r   <= esm_pkg::START_PATIENCE_RESET;
      slot_r       <= '0;
      fill_r       <= '0;
      best_known_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          esm_pkg::REG_CHECK_INTERVAL:    interval_r <= cfg_data[15:0];
          esm_pkg::REG_IMPROVE_THRESHOLD: thr_r      <= cfg_data[15:0];
          esm_pkg::REG_PATIENCE_GROWTH:   growth_r   <= cfg_data[15:0];
          esm_pkg::REG_BOX_SIZE:          box_r      <= cfg_data[4:0];
          esm_pkg::REG_START_PATIENCE:    patience_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == S_WRITE) begin
        slot_r <= slot_inc;
        fill_r <= fill_inc;
      end
      if (state_r == S_SIG) begin
        best_known_r <= 1'b1;
      end
      if ((state_r == S_GROW) && (grown_sat > patience_r)) begin
        patience_r <= grown_sat;
      end
      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      epoch_r <= in_epoch;
      upd_r   <= in_updates;
      loss_r  <= in_loss;
      inv_r   <= in_loss_invalid;
      chk_r   <= 1'b0;
      save_r  <= 1'b0;
      mean_r  <= '0;
    end
    if ((state_r == S_MOD) && div_stat.done) begin
      chk_r <= (div_rem == '0);
    end
    if (state_r == S_WRITE) begin
      rd_addr_r <= slot_r;
      window_r  <= (fill_inc < box_eff) ? fill_inc : box_eff;
      issued_r  <= '0;
      pend_r    <= 1'b0;
      sum_r     <= '0;
    end
    if (state_r == S_READ) begin
      if (issued_r != window_r) begin
        rd_addr_r <= rd_dec;
        issued_r  <= issued_r + esm_pkg::CNT_W'(1);
        pend_r    <= 1'b1;
      end else begin
        pend_r <= 1'b0;
      end
      if (pend_r) begin
        sum_r <= sum_r + esm_pkg::SUM_W'(rdata);
      end
    end
    if ((state_r == S_DIV) && div_stat.done) begin
      mean_r <= div_quo[LW-1:0];
    end
    if (state_r == S_BEST) begin
      prod_r <= mul_p;
    end
    if (state_r == S_SIG) begin
      save_r <= 1'b1;
      best_r <= mean_r;
      prod_r <= mul_p;
    end
    if ((state_r == S_FIN) && out_free) begin
      out_checked_r <= chk_r;
      out_save_r    <= save_r;
      out_stop_r    <= stop_code;
      out_mean_r    <= mean_r;
      out_pat_r     <= patience_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_checked      = out_checked_r;
  assign out_save_params  = out_save_r;
  assign out_stop_code    = out_stop_r;
  assign out_mean_loss    = out_mean_r;
  assign out_patience_now = out_pat_r;

endmodule

// ===== rtl/esm_ram.sv =====
// esm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module esm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                           clk,
  input  logic                                           we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                               wdata,
  input  logic                                           re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                               rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/esm_div.sv =====
// esm_div: bit-serial restoring divider, one quotient bit per cycle.
// Depends on esm_pkg for widths and the status struct.
module esm_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [esm_pkg::DIV_W-1:0]    dividend,
  input  logic [esm_pkg::DVS_W-1:0]    divisor,
  output esm_pkg::div_stat_t           stat,
  output logic [esm_pkg::DIV_W-1:0]    quotient,
  output logic [esm_pkg::DVS_W-1:0]    remainder
);
  logic [esm_pkg::DIV_W-1:0]  quo_r;
  logic [esm_pkg::DVS_W-1:0]  rem_r;
  logic [esm_pkg::DVS_W-1:0]  dvs_r;
  logic [esm_pkg::DCNT_W-1:0] cnt_r;
  logic                       done_r;

  logic [esm_pkg::DVS_W:0]    shifted;
  logic [esm_pkg::DVS_W:0]    diff;
  logic                       ge;

  assign shifted = {rem_r, quo_r[esm_pkg::DIV_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = (shifted >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= esm_pkg::DCNT_W'(esm_pkg::DIV_W);
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == esm_pkg::DCNT_W'(1));
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - esm_pkg::DCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[esm_pkg::DIV_W-2:0], ge};
      rem_r <= ge ? diff[esm_pkg::DVS_W-1:0] : shifted[esm_pkg::DVS_W-1:0];
    end
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== tb/early_stopping_monitor_test.sv =====
// early_stopping_monitor_test: self-checking bench for the early stopping monitor.
// Drives a directed plan, then random training runs; checks every result word
// against an in-bench predictor or typed row. Depends on esm_pkg, early_stopping_monitor.
module early_stopping_monitor_test;

  localparam int LW               = esm_pkg::LOSS_WIDTH;
  localparam int HDEPTH           = esm_pkg::HISTORY_DEPTH;
  localparam int RANDOM_ITEMS     = 700;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int LONG_HOLD_AT     = 150;
  localparam int LONG_HOLD_CYCLES = 600;

  typedef struct packed {
    logic          checked;
    logic          save_params;
    logic [1:0]    stop_code;
    logic [LW-1:0] mean_loss;
    logic [31:0]   patience_now;
  } report_result_t;

  typedef enum logic {ROW_REPORT, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    row_kind_t      kind;
    logic [2:0]     reg_idx;
    logic [31:0]    reg_value;
    logic [31:0]    epoch;
    logic [31:0]    updates;
    logic [LW-1:0]  loss;
    logic           loss_invalid;
    logic           typed;
    report_result_t want;
  } plan_row_t;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic [31:0]   in_epoch;
  logic [31:0]   in_updates;
  logic [LW-1:0] in_loss;
  logic          in_loss_invalid;
  logic          out_valid;
  logic          out_stall;
  logic          out_checked;
  logic          out_save_params;
  logic [1:0]    out_stop_code;
  logic [LW-1:0] out_mean_loss;
  logic [31:0]   out_patience_now;
  logic          cfg_we;
  logic [2:0]    cfg_index;
  logic [31:0]   cfg_data;

  early_stopping_monitor DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_epoch         (in_epoch),
    .in_updates       (in_updates),
    .in_loss          (in_loss),
    .in_loss_invalid  (in_loss_invalid),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_checked      (out_checked),
    .out_save_params  (out_save_params),
    .out_stop_code    (out_stop_code),
    .out_mean_loss    (out_mean_loss),
    .out_patience_now (out_patience_now),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #4 clk = ~clk;

  // register mirror
  logic [15:0] chk_interval;
  logic [15:0] thr_q16;
  logic [15:0] growth_q12;
  logic [4:0]  box_len;

  // predictor state
  logic [LW-1:0] loss_ring [HDEPTH];
  int            ring_slot;
  int            ring_fill;
  logic [LW-1:0] best_mean;
  logic          best_valid;
  logic [31:0]   patience_cur;

  report_result_t pending_results [$];
  plan_row_t      plan [$];

  int   mismatches = 0;
  int   results_seen = 0;
  int   reports_sent = 0;
  int   random_sent = 0;
  int   quiet_cycles = 0;
  logic long_hold_done = 1'b0;
  logic steady_sender = 1'b0;
  logic [LW-1:0] loss_level;
  logic [31:0]   run_epoch;
  logic [31:0]   run_updates;

  function automatic void add_row(input plan_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  function automatic void add_expected(input report_result_t res);
    pending_results.insert(pending_results.size(), res);
  endfunction

  function automatic report_result_t predict_report(input logic [31:0] epoch,
      input logic [31:0] updates, input logic [LW-1:0] loss, input logic invalid);
    report_result_t res;
    logic [15:0] interval;
    int box;
    int window;
    int slot;
    logic [esm_pkg::SUM_W-1:0] sum;
    logic [LW-1:0] mean;
    logic [LW+15:0] mean_scaled;
    logic [LW+15:0] best_scaled;
    logic [47:0] growth_prod;
    logic [35:0] grown;
    res = '0;
    res.patience_now = patience_cur;
    interval = (chk_interval == 16'd0) ? 16'd1 : chk_interval;
    if (epoch % interval != 0) begin
      res.checked = 1'b0;
    end else if (invalid) begin
      res.checked = 1'b1;
      res.stop_code = esm_pkg::STOP_INVALID;
    end else begin
      res.checked = 1'b1;
      loss_ring[ring_slot] = loss;
      ring_slot = (ring_slot + 1) % HDEPTH;
      if (ring_fill < HDEPTH) ring_fill++;
      box = (box_len == 5'd0) ? 1 : box_len;
      if (box > HDEPTH) box = HDEPTH;
      window = (ring_fill < box) ? ring_fill : box;
      sum = '0;
      slot = ring_slot;
      for (int i = 0; i < window; i++) begin
        slot = (slot + HDEPTH - 1) % HDEPTH;
        sum = sum + loss_ring[slot];
      end
      mean = LW'(sum / window);
      if (!best_valid || mean < best_mean) begin
        res.save_params = 1'b1;
        // significance: mean < thr * best, compared exactly at full width
        mean_scaled = {mean, 16'h0000};
        best_scaled = best_mean * thr_q16;
        if (!best_valid || mean_scaled < best_scaled) begin
          growth_prod = updates * growth_q12;
          grown = growth_prod[47:12];
          if (grown > 36'hFFFFFFFF) grown = 36'hFFFFFFFF;
          if (grown > patience_cur) patience_cur = grown[31:0];
        end
        best_mean = mean;
        best_valid = 1'b1;
      end
      res.stop_code = (patience_cur <= epoch) ? esm_pkg::STOP_NO_IMPR :
                      esm_pkg::STOP_CONTINUE;
      res.mean_loss = mean;
      res.patience_now = patience_cur;
    end
    return res;
  endfunction

  function automatic int pick_idle();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 24);
    return $urandom_range(40, 90);
  endfunction

  function automatic logic [31:0] pick_reg_value(input logic [2:0] idx);
    int roll;
    logic [31:0] v;
    roll = $urandom_range(0, 9);
    case (idx)
      esm_pkg::REG_CHECK_INTERVAL: begin
        if (roll < 2) v = $urandom_range(0, 1) ? 32'd0 : 32'd65535;
        else if (roll < 8) v = $urandom_range(1, 4);
        else v = $urandom_range(0, 65535);
      end
      esm_pkg::REG_IMPROVE_THRESHOLD: begin
        if (roll < 2) v = $urandom_range(0, 1) ? 32'd0 : 32'd65535;
        else if (roll < 9) v = $urandom_range(60000, 65535);
        else v = $urandom_range(0, 65535);
      end
      esm_pkg::REG_PATIENCE_GROWTH: begin
        if (roll < 2) v = $urandom_range(0, 1) ? 32'd4097 : 32'd65535;
        else if (roll < 9) v = $urandom_range(4097, 12288);
        else v = $urandom_range(4097, 65535);
      end
      esm_pkg::REG_BOX_SIZE: begin
        if (roll < 2) v = $urandom_range(0, 1) ? 32'd0 : 32'd16;
        else if (roll < 8) v = $urandom_range(1, 8);
        else v = $urandom_range(9, 31);
      end
      default: begin
        if (roll < 2) v = $urandom_range(0, 1) ? 32'd0 : 32'hFFFFFFFF;
        else if (roll < 6) v = $urandom_range(0, 2000);
        else v = $urandom_range(2000, 100000);
      end
    endcase
    return v;
  endfunction

  // loss trend of a training run: mostly falling, now and then a bump
  function automatic logic [LW-1:0] next_loss_level();
    int roll;
    logic [LW:0] step;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      if (roll < 45) step = (loss_level >> 6) + $urandom_range(0, 255);
      else if (roll < 60) step = loss_level >> 4;
      else step = loss_level >> 11;
      loss_level = (step >= loss_level) ? '0 : loss_level - step[LW-1:0];
    end else begin
      step = {1'b0, loss_level} + (loss_level >> 5) + 1;
      loss_level = step[LW] ? '1 : step[LW-1:0];
    end
    return loss_level;
  endfunction

  function automatic void plan_config(input logic [2:0] idx, input logic [31:0] value);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CONFIG;
    r.reg_idx = idx;
    r.reg_value = value;
    add_row(r);
  endfunction

  function automatic void plan_report(input logic [31:0] epoch, input logic [31:0] updates,
      input logic [LW-1:0] loss, input logic invalid);
    plan_row_t r;
    r = '0;
    r.kind = ROW_REPORT;
    r.epoch = epoch;
    r.updates = updates;
    r.loss = loss;
    r.loss_invalid = invalid;
    add_row(r);
  endfunction

  function automatic void plan_typed(input logic [31:0] epoch, input logic [31:0] updates,
      input logic [LW-1:0] loss, input logic invalid, input logic chk, input logic save,
      input logic [1:0] stop, input logic [LW-1:0] mean, input logic [31:0] pat);
    plan_row_t r;
    r = '0;
    r.kind = ROW_REPORT;
    r.epoch = epoch;
    r.updates = updates;
    r.loss = loss;
    r.loss_invalid = invalid;
    r.typed = 1'b1;
    r.want.checked = chk;
    r.want.save_params = save;
    r.want.stop_code = stop;
    r.want.mean_loss = mean;
    r.want.patience_now = pat;
    add_row(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
      input logic [31:0] want);
    mismatches++;
    $display("mismatch in result %0d: %s got %h, expected %h", results_seen, what, got, want);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      esm_pkg::REG_CHECK_INTERVAL:    chk_interval = value[15:0];
      esm_pkg::REG_IMPROVE_THRESHOLD: thr_q16 = value[15:0];
      esm_pkg::REG_PATIENCE_GROWTH:   growth_q12 = value[15:0];
      esm_pkg::REG_BOX_SIZE:          box_len = value[4:0];
      esm_pkg::REG_START_PATIENCE:    patience_cur = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_report(input logic [31:0] epoch, input logic [31:0] updates,
      input logic [LW-1:0] loss, input logic invalid, input logic typed,
      input report_result_t want);
    report_result_t predicted;
    int gap;
    in_valid <= 1'b1;
    in_epoch <= epoch;
    in_updates <= updates;
    in_loss <= loss;
    in_loss_invalid <= invalid;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = predict_report(epoch, updates, loss, invalid);
    add_expected(typed ? want : predicted);
    reports_sent++;
    gap = steady_sender ? 0 : pick_idle();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // registers change only with nothing in flight
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    report_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("word with nothing pending", out_patience_now, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_checked !== want.checked)
          report_mismatch("checked", 32'(out_checked), 32'(want.checked));
        if (out_save_params !== want.save_params)
          report_mismatch("save_params", 32'(out_save_params), 32'(want.save_params));
        if (out_stop_code !== want.stop_code)
          report_mismatch("stop_code", 32'(out_stop_code), 32'(want.stop_code));
        if (out_mean_loss !== want.mean_loss)
          report_mismatch("mean_loss", 32'(out_mean_loss), 32'(want.mean_loss));
        if (out_patience_now !== want.patience_now)
          report_mismatch("patience_now", out_patience_now, want.patience_now);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("early_stopping_monitor regression: fail");
    $finish;
  end

  // receiver: random stalls, calm stretches, one long hold to back up the input
  initial begin : receiver
    int run_len;
    int hold_len;
    int roll;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!long_hold_done && reports_sent >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        roll = $urandom_range(0, 99);
        run_len = (roll < 15) ? $urandom_range(50, 200) : $urandom_range(1, 12);
        hold_len = pick_idle();
        out_stall <= 1'b0;
        repeat (run_len) @(posedge clk);
        if (hold_len != 0) begin
          out_stall <= 1'b1;
          repeat (hold_len) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int phase_len;
    int roll;
    logic [31:0] upd_step;
    logic [31:0] epoch_step;
    logic [LW:0] noisy;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_epoch <= '0;
    in_updates <= '0;
    in_loss <= '0;
    in_loss_invalid <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= esm_pkg::REG_CHECK_INTERVAL;
    cfg_data <= '0;

    chk_interval = 16'd1;
    thr_q16 = 16'd65208;
    growth_q12 = 16'd8192;
    box_len = 5'd1;
    ring_slot = 0;
    ring_fill = 0;
    best_mean = '0;
    best_valid = 1'b0;
    patience_cur = esm_pkg::START_PATIENCE_RESET;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first word after reset: no best yet, so it saves
    plan_typed(32'd0, 32'd0, '1, 1'b0, 1'b1, 1'b1, esm_pkg::STOP_CONTINUE, '1,
               esm_pkg::START_PATIENCE_RESET);
    plan_typed(32'd5, 32'hFFFFFFFF, '0, 1'b1, 1'b1, 1'b0, esm_pkg::STOP_INVALID, '0,
               esm_pkg::START_PATIENCE_RESET);
    plan_report(32'd1, 32'd1000, 32'h80000000, 1'b0);
    plan_config(esm_pkg::REG_CHECK_INTERVAL, 32'd3);
    plan_typed(32'd4, 32'd77, 32'h12345678, 1'b0, 1'b0, 1'b0, esm_pkg::STOP_CONTINUE, '0,
               esm_pkg::START_PATIENCE_RESET);
    plan_report(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 1'b0);
    plan_config(esm_pkg::REG_CHECK_INTERVAL, 32'd0);
    plan_report(32'd7, 32'd3, 32'h40000000, 1'b0);
    plan_config(esm_pkg::REG_CHECK_INTERVAL, 32'd65535);
    plan_report(32'd65534, 32'd9, 32'h01000000, 1'b0);
    plan_report(32'd131070, 32'd50000, 32'h3F000000, 1'b0);
    plan_config(esm_pkg::REG_CHECK_INTERVAL, 32'd1);
    plan_config(esm_pkg::REG_BOX_SIZE, 32'd16);
    plan_report(32'd10, 32'd60000, 32'h30000000, 1'b0);
    plan_report(32'd11, 32'd61000, 32'h38000000, 1'b0);
    plan_report(32'd12, 32'd62000, 32'h20000000, 1'b0);
    plan_report(32'd13, 32'd63000, 32'h2F000000, 1'b0);
    plan_config(esm_pkg::REG_BOX_SIZE, 32'd0);
    plan_report(32'd14, 32'd64000, 32'h1E000000, 1'b0);
    plan_config(esm_pkg::REG_BOX_SIZE, 32'd31);
    plan_report(32'd15, 32'd65000, 32'h1D000000, 1'b0);
    plan_config(esm_pkg::REG_BOX_SIZE, 32'd1);
    plan_config(esm_pkg::REG_PATIENCE_GROWTH, 32'd65535);
    plan_config(esm_pkg::REG_IMPROVE_THRESHOLD, 32'd65535);
    // growth product overflows 32 bits: patience saturates
    plan_report(32'd16, 32'hFFFFFFFF, 32'h10000000, 1'b0);
    plan_config(esm_pkg::REG_IMPROVE_THRESHOLD, 32'd0);
    plan_report(32'd17, 32'h00FFFFFF, 32'h0F000000, 1'b0);
    plan_config(esm_pkg::REG_PATIENCE_GROWTH, 32'd4097);
    plan_config(esm_pkg::REG_START_PATIENCE, 32'hFFFFFFFF);
    plan_report(32'hFFFFFFFF, 32'd1, 32'h0E000000, 1'b0);
    plan_config(esm_pkg::REG_START_PATIENCE, 32'd0);
    plan_report(32'd0, 32'd0, 32'h0E800000, 1'b0);
    plan_report(32'd18, 32'd2, '1, 1'b1);

    foreach (plan[n]) begin
      if (plan[n].kind == ROW_CONFIG) begin
        drain_results();
        write_reg(plan[n].reg_idx, plan[n].reg_value);
      end else begin
        send_report(plan[n].epoch, plan[n].updates, plan[n].loss, plan[n].loss_invalid,
                    plan[n].typed, plan[n].want);
      end
    end

    // random training runs, one register setting per phase
    loss_level = 32'h0D000000;
    run_epoch = 32'd20;
    run_updates = 32'd100;
    while (random_sent < RANDOM_ITEMS) begin
      drain_results();
      for (int r = 0; r <= int'(esm_pkg::REG_START_PATIENCE); r++)
        if ($urandom_range(0, 1)) write_reg(3'(r), pick_reg_value(3'(r)));
      steady_sender = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) run_epoch = $urandom;
      upd_step = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 40);
      epoch_step = (chk_interval == 16'd0) ? 32'd1 : 32'(chk_interval);
      phase_len = $urandom_range(40, 100);
      if (phase_len > RANDOM_ITEMS - random_sent) phase_len = RANDOM_ITEMS - random_sent;
      for (int k = 0; k < phase_len; k++) begin
        roll = $urandom_range(0, 99);
        run_epoch = run_epoch + (($urandom_range(0, 3) == 0) ? 32'd1 : epoch_step);
        run_updates = run_updates + upd_step;
        if (roll < 80) begin
          send_report(run_epoch, run_updates, next_loss_level(), 1'b0, 1'b0, '0);
        end else if (roll < 88) begin
          send_report(run_epoch, run_updates, $urandom, 1'b1, 1'b0, '0);
        end else if (roll < 94) begin
          // stray report: random counters, loss no better than the trend
          noisy = {1'b0, loss_level} + $urandom_range(0, 65535);
          send_report($urandom, $urandom, noisy[LW] ? '1 : noisy[LW-1:0], 1'b0, 1'b0, '0);
        end else begin
          send_report($urandom, $urandom, $urandom, 1'b1, 1'b0, '0);
        end
        random_sent++;
      end
    end

    drain_results();
    repeat (128) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("early_stopping_monitor regression: pass");
    else
      $display("early_stopping_monitor regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/esm_pkg.sv
rtl/esm_ram.sv
rtl/esm_div.sv
rtl/early_stopping_monitor.sv
tb/early_stopping_monitor_test.sv
